>>> rtl/rses_pkg.sv
// Shared types and constants for the rotary encoder and switch scanner.
package rses_pkg;

  // Bit positions of the sticky flags and of the matching clear strobes
  localparam int FlagUp    = 0;
  localparam int FlagDown  = 1;
  localparam int FlagPress = 2;
  localparam int FlagHold  = 3;
  localparam int FlagPrel  = 4;
  localparam int FlagHrel  = 5;
  localparam int NumFlags  = 6;

  // Configuration register indexes
  localparam logic [7:0] RegScanDivider  = 8'd0;
  localparam logic [7:0] RegHoldThreshold = 8'd1;

  // Reset values of the configuration registers
  localparam logic [7:0]  ScanDividerRst  = 8'd10;
  localparam logic [15:0] HoldThresholdRst = 16'd100;

  // One sampled input item
  typedef struct packed {
    logic [5:0] clear_mask;
    logic       switch_pin;
    logic [1:0] phase_pins;
  } item_t;

  // Configuration seen by the scan logic
  typedef struct packed {
    logic [7:0]  scan_divider;
    logic [15:0] hold_threshold;
  } cfg_t;

endpackage

>>> rtl/rses_in_stage.sv
// Input register stage of the scanner: holds one item until the scan stage takes it.
module rses_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rses_pkg::item_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rses_pkg::item_t out_item_o
);

  logic            valid_q, valid_d;
  rses_pkg::item_t item_q;

  // Register is free when empty or being drained this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> rtl/rses_scan.sv
// Scan stage: prescaler, switch and encoder state, and the result register.
module rses_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rses_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rses_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [rses_pkg::NumFlags-1:0] out_flags_o
);

  logic [7:0]  cnt_q, cnt_d, cnt_dec;
  logic [15:0] scans_q, scans_d;
  logic        pmem_q, pmem_d;
  logic        hmem_q, hmem_d;
  logic [1:0]  lphase_q, lphase_d;
  logic        ldir_q, ldir_d;
  logic [rses_pkg::NumFlags-1:0] flags_q, flags_d;
  logic        ovalid_q, ovalid_d;
  logic        advance;
  logic        scan;
  logic        dir;

  assign in_ready_o = !ovalid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;
  assign cnt_dec    = cnt_q - 8'd1;
  assign scan       = (cnt_dec == 8'd0);
  assign dir        = in_item_i.phase_pins[0] ^ lphase_q[1];

  // Next state for one item: clears first, then a scan when the prescaler expires
  always_comb begin
    cnt_d    = cnt_q;
    scans_d  = scans_q;
    pmem_d   = pmem_q;
    hmem_d   = hmem_q;
    lphase_d = lphase_q;
    ldir_d   = ldir_q;
    flags_d  = flags_q;
    if (advance) begin
      flags_d = flags_q & ~in_item_i.clear_mask;
      cnt_d   = cnt_dec;
      if (scan) begin
        cnt_d = cfg_i.scan_divider;
        // Switch: active low
        if (!in_item_i.switch_pin) begin
          if (scans_q < cfg_i.hold_threshold) begin
            scans_d = scans_q + 16'd1;
            if (!pmem_q) begin
              flags_d[rses_pkg::FlagPress] = 1'b1;
            end
            pmem_d = 1'b1;
          end else begin
            if (!hmem_q) begin
              flags_d[rses_pkg::FlagHold] = 1'b1;
            end
            hmem_d = 1'b1;
            flags_d[rses_pkg::FlagPress] = 1'b0;
            pmem_d = 1'b0;
          end
        end else begin
          scans_d = 16'd0;
          flags_d[rses_pkg::FlagPrel] = pmem_q;
          flags_d[rses_pkg::FlagHrel] = hmem_q;
          pmem_d = 1'b0;
          hmem_d = 1'b0;
        end
        // Encoder: step only on return to detent in a steady direction
        if (in_item_i.phase_pins != lphase_q) begin
          if ((dir == ldir_q) && (in_item_i.phase_pins == 2'b00)) begin
            flags_d[rses_pkg::FlagUp]   = !dir;
            flags_d[rses_pkg::FlagDown] = dir;
          end
          ldir_d   = dir;
          lphase_d = in_item_i.phase_pins;
        end
      end
    end
  end

  // Result valid handshake
  always_comb begin
    ovalid_d = ovalid_q;
    if (in_ready_o) begin
      ovalid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 8'd1;
      scans_q  <= 16'd0;
      pmem_q   <= 1'b0;
      hmem_q   <= 1'b0;
      lphase_q <= 2'b00;
      ldir_q   <= 1'b0;
      flags_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      scans_q  <= scans_d;
      pmem_q   <= pmem_d;
      hmem_q   <= hmem_d;
      lphase_q <= lphase_d;
      ldir_q   <= ldir_d;
      flags_q  <= flags_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_flags_o = flags_q;

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ovalid_q)
    else $error("result dropped while stalled");

  // A stalled result keeps the flags and the prescaler unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ($stable(flags_q) && $stable(cnt_q)))
    else $error("state moved while result stalled");

  // A step flag only rises on a scan of an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(flags_q[rses_pkg::FlagUp]) || $rose(flags_q[rses_pkg::FlagDown]))
      |-> $past(advance && scan))
    else $error("step flag set outside a scan");

  // Release flags only rise on a scan with the switch released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(flags_q[rses_pkg::FlagPrel]) || $rose(flags_q[rses_pkg::FlagHrel]))
      |-> $past(advance && scan && in_item_i.switch_pin))
    else $error("release flag set outside a release scan");

endmodule

>>> rtl/rotary_encoder_switch_scanner_unit.sv
// Top level of the rotary encoder and push switch scanner: ports, configuration, stages.
//
// Channel  Direction  Handshake                 Content
// s_axis   in         s_axis_tvalid/tready      one pin sample and clear strobes per item
// m_axis   out        m_axis_tvalid/tready      six sticky flags after that item
// cfg      in         cfg_valid/cfg_ready       register index and write data
//
// One item is accepted every cycle while the result is not stalled; each item
// passes the input register, then the scan logic into the result register.
// Reset sets scan_divider to 10 and hold_threshold to 100, the prescaler to 1
// (first item scans) and clears all flags and switch and encoder state.
// A stalled result stops the scan stage; the input register still takes one item.
// Configuration writes are always ready and take effect at the next scan.
module rotary_encoder_switch_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] phase_pins, [2] switch_pin, [8:3] clear_mask, [15:9] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] step_up, [1] step_down, [2] pressed, [3] held,
  // [4] press_released, [5] hold_released, [7:6] zero
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  rses_pkg::cfg_t  cfg_q;
  rses_pkg::item_t in_item;
  rses_pkg::item_t st_item;
  logic            st_valid, st_ready;
  logic [rses_pkg::NumFlags-1:0] flags;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_divider   <= rses_pkg::ScanDividerRst;
      cfg_q.hold_threshold <= rses_pkg::HoldThresholdRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rses_pkg::RegScanDivider:   cfg_q.scan_divider   <= cfg_data_i[7:0];
        rses_pkg::RegHoldThreshold: cfg_q.hold_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input item
  assign in_item.phase_pins = s_axis_tdata[1:0];
  assign in_item.switch_pin = s_axis_tdata[2];
  assign in_item.clear_mask = s_axis_tdata[8:3];

  rses_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (st_valid),
    .out_ready_i (st_ready),
    .out_item_o  (st_item)
  );

  rses_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (st_valid),
    .in_ready_o  (st_ready),
    .in_item_i   (st_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_flags_o (flags)
  );

  assign m_axis_tdata = {2'b00, flags};

endmodule

>>> sim/tb.sv
// Testbench for the rotary encoder and push switch scanner: stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb;

  localparam int CycleLimit    = 200000;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 4;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // DUT ports
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  rotary_encoder_switch_scanner_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Scanner state mirrored by the predictor
  logic [7:0]  cfg_div      = rses_pkg::ScanDividerRst;
  logic [15:0] cfg_thr      = rses_pkg::HoldThresholdRst;
  logic [7:0]  prescale     = 8'd1;
  logic [15:0] press_scans  = '0;
  logic        press_mem    = 1'b0;
  logic        hold_mem     = 1'b0;
  logic [1:0]  last_phase   = 2'b00;
  logic        last_dir     = 1'b0;
  logic [rses_pkg::NumFlags-1:0] flags = '0;

  // Flag words still owed by the DUT, oldest first
  logic [rses_pkg::NumFlags-1:0] flags_due [$];

  string flag_name [rses_pkg::NumFlags] = '{"step_up", "step_down", "pressed", "held",
                                            "press_released", "hold_released"};

  int errors    = 0;
  int cycles    = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_scans   = 0;
  int n_up      = 0;
  int n_down    = 0;
  int n_presses = 0;
  int n_holds   = 0;
  int n_configs = 0;

  // Idling controls
  bit tx_idle       = 1'b0;
  bit rx_stalls     = 1'b0;
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int stall_left    = 0;

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the mirrored scanner by one item and queue its flag word
  task automatic scanner_predict(input rses_pkg::item_t it);
    logic dir;
    flags = flags & ~it.clear_mask;
    prescale = prescale - 8'd1;
    if (prescale == 8'd0) begin
      prescale = cfg_div;
      n_scans++;
      // switch
      if (!it.switch_pin) begin
        if (press_scans < cfg_thr) begin
          press_scans = press_scans + 16'd1;
          if (!press_mem) begin
            flags[rses_pkg::FlagPress] = 1'b1;
            n_presses++;
          end
          press_mem = 1'b1;
        end else begin
          if (!hold_mem) begin
            flags[rses_pkg::FlagHold] = 1'b1;
            n_holds++;
          end
          hold_mem = 1'b1;
          flags[rses_pkg::FlagPress] = 1'b0;
          press_mem = 1'b0;
        end
      end else begin
        press_scans = '0;
        flags[rses_pkg::FlagPrel] = press_mem;
        flags[rses_pkg::FlagHrel] = hold_mem;
        press_mem = 1'b0;
        hold_mem = 1'b0;
      end
      // encoder: step only at detent when direction repeats
      if (it.phase_pins != last_phase) begin
        dir = it.phase_pins[0] ^ last_phase[1];
        if (dir == last_dir && it.phase_pins == 2'b00) begin
          flags[rses_pkg::FlagUp]   = !dir;
          flags[rses_pkg::FlagDown] = dir;
          if (dir) n_down++;
          else n_up++;
        end
        last_dir = dir;
        last_phase = it.phase_pins;
      end
    end
    flags_due.push_back(flags);
  endtask

  // Input and config monitor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      n_items++;
      scanner_predict(rses_pkg::item_t'(s_axis_tdata[8:0]));
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rses_pkg::RegScanDivider:   cfg_div = cfg_data_i[7:0];
        rses_pkg::RegHoldThreshold: cfg_thr = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    logic [rses_pkg::NumFlags-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (flags_due.size() == 0) begin
        $error("result with no item pending: %b", m_axis_tdata[rses_pkg::NumFlags-1:0]);
        errors++;
      end else begin
        want = flags_due.pop_front();
        n_results++;
        for (int i = 0; i < rses_pkg::NumFlags; i++) begin
          if (want[i] !== m_axis_tdata[i]) begin
            $error("%s: expected %0b, got %0b", flag_name[i], want[i], m_axis_tdata[i]);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen <= hold_off_reqs;
      stall_left    <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
      stall_left    <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item; valid stays high until a gap or an idle wait lowers it
  task automatic send_item(input logic [1:0] pins, input logic sw, input logic [5:0] clr);
    rses_pkg::item_t it;
    it.phase_pins = pins;
    it.switch_pin = sw;
    it.clear_mask = clr;
    if (tx_idle && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and let every owed result drain; wait on the clock first so the
  // last accepted item is already queued by the monitor
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (flags_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers; junk in the divider's upper byte must be ignored
  task automatic set_config(input logic [7:0] div, input logic [15:0] thr);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= rses_pkg::RegScanDivider;
    cfg_data_i  <= {junk, div};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= rses_pkg::RegHoldThreshold;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_configs++;
  endtask

  // Well-formed rotations and presses, with glitches, broken sequences and clears
  task automatic run_random(input logic [7:0] div, input logic [15:0] thr, input int n,
                            input bit pressure);
    int eff_div, thr_cap, ph_left, sw_left;
    logic [1:0] ph, pins;
    logic sw, up;
    logic [5:0] clr;
    set_config(div, thr);
    eff_div = (div == 8'd0) ? 256 : int'(div);
    thr_cap = (thr > 16'd6) ? 6 : int'(thr);
    ph = last_phase;
    sw = 1'b1;
    up = 1'($urandom_range(0, 1));
    ph_left = 0;
    sw_left = eff_div * $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      if (ph_left == 0) begin
        if ($urandom_range(0, 99) < 15) begin
          ph = 2'($urandom_range(0, 3));
        end else begin
          if ($urandom_range(0, 99) < 10) up = !up;
          // gray order: up 00-10-11-01-00, down the reverse
          case (ph)
            2'b00:   ph = up ? 2'b10 : 2'b01;
            2'b01:   ph = up ? 2'b00 : 2'b11;
            2'b10:   ph = up ? 2'b11 : 2'b00;
            default: ph = up ? 2'b01 : 2'b10;
          endcase
        end
        ph_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, eff_div)
                                                : $urandom_range(eff_div, 2 * eff_div);
      end
      ph_left--;
      if (sw_left == 0) begin
        sw = !sw;
        sw_left = eff_div * $urandom_range(1, thr_cap + 3);
      end
      sw_left--;
      pins = ($urandom_range(0, 99) < 3) ? 2'($urandom_range(0, 3)) : ph;
      clr  = ($urandom_range(0, 99) < 15) ? 6'($urandom_range(0, 63)) : 6'd0;
      if (pressure && k == n / 2) hold_off_reqs <= hold_off_reqs + 1;
      send_item(pins, sw, clr);
    end
  endtask

  // First item after reset scans with the reset configuration
  task automatic test_reset_scan();
    send_item(2'b10, 1'b1, 6'd0);
    send_item(2'b11, 1'b0, 6'd0);
    send_item(2'b11, 1'b1, 6'd0);
  endtask

  // Steps up and down, a reversal without step, and clearing of the step flags
  task automatic test_encoder_steps();
    set_config(8'd1, 16'd3);
    send_item(2'b00, 1'b1, 6'd0);
    send_item(2'b10, 1'b1, 6'd0);
    send_item(2'b11, 1'b1, 6'd0);
    send_item(2'b01, 1'b1, 6'd0);
    send_item(2'b00, 1'b1, 6'd0);
    send_item(2'b01, 1'b1, 6'd0);
    send_item(2'b11, 1'b1, 6'd0);
    send_item(2'b10, 1'b1, 6'd0);
    send_item(2'b00, 1'b1, 6'b000011);
    send_item(2'b10, 1'b1, 6'b000011);
    send_item(2'b00, 1'b1, 6'd0);
  endtask

  // Press, hold, release flags; hold on first scan; clear and set in one item
  task automatic test_switch_flags();
    set_config(8'd1, 16'd0);
    send_item(2'b00, 1'b0, 6'd0);
    send_item(2'b00, 1'b0, 6'd0);
    send_item(2'b00, 1'b1, 6'd0);
    send_item(2'b00, 1'b1, 6'd0);
    set_config(8'd1, 16'd2);
    send_item(2'b00, 1'b0, 6'b000100);
    send_item(2'b00, 1'b0, 6'd0);
    send_item(2'b00, 1'b0, 6'd0);
    send_item(2'b00, 1'b1, 6'd0);
    send_item(2'b00, 1'b0, 6'd0);
    send_item(2'b00, 1'b1, 6'd0);
    send_item(2'b11, 1'b0, 6'h3F);
    send_item(2'b11, 1'b1, 6'h3F);
  endtask

  // Random stimulus across divider and threshold settings, extremes included
  task automatic test_random_configs();
    tx_idle   = 1'b1;
    rx_stalls = 1'b1;
    run_random(8'd1, 16'd1, 250, 1'b0);
    run_random(8'd2, 16'd4, 250, 1'b0);
    run_random(8'd255, 16'd65535, 300, 1'b0);
    run_random(8'd0, 16'd0, 300, 1'b0);
    tx_idle   = 1'b0;
    rx_stalls = 1'b0;
    run_random(8'd3, 16'd2, 100, 1'b0);
    tx_idle   = 1'b1;
    rx_stalls = 1'b1;
    run_random(8'($urandom_range(1, 12)), 16'($urandom_range(1, 6)), 150, 1'b0);
  endtask

  // Long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    tx_idle   = 1'b0;
    rx_stalls = 1'b0;
    run_random(8'd1, 16'd3, 200, 1'b1);
    tx_idle   = 1'b1;
    rx_stalls = 1'b1;
    run_random(8'd4, 16'd3, 100, 1'b0);
  endtask

  // Sequence the tests
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_scan();
    test_encoder_steps();
    test_switch_flags();
    test_random_configs();
    test_backpressure();
    wait_idle();
    $display("Ran %0d items and checked %0d results over %0d register settings, %0d scans",
             n_items, n_results, n_configs, n_scans);
    $display("Predicted %0d up steps, %0d down steps, %0d presses and %0d holds",
             n_up, n_down, n_presses, n_holds);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
